// File: hdl/sbmq_pkg.sv
package sbmq_pkg;

	localparam int SLOTS  = 16;
	localparam int QUEUES = 4;

	localparam int PW  = $clog2(SLOTS + 1);
	localparam int SIW = $clog2(SLOTS);
	localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int DW  = 32;

	localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic exec;
		logic fin;
	} sbmq_cmd_t;

endpackage

// File: hdl/shared_buffer_multi_queue.sv
// Channel   Handshake                     Payload
// command   start, accepted when !busy    func, queue_num, data_in
// result    done, one-cycle strobe        status, data_out
//
// Each command has an accept edge, which updates heads, links and the free list,
// and a finishing cycle, which writes the end-of-queue link of an enqueued slot.
// The result strobe appears in the cycle after that, while a new command can be taken.
// Reset is asynchronous and puts all slots on the free list with every queue empty.
// The receiver cannot stall, so results are never held.
module shared_buffer_multi_queue
	import sbmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [1:0]           queue_num,
	input  logic signed [DW-1:0] data_in,
	output logic                 done,
	output logic [1:0]           status,
	output logic signed [DW-1:0] data_out
);

	sbmq_cmd_t cmd;

	sbmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	sbmq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.queue_num (queue_num),
		.data_in   (data_in),
		.done      (done),
		.status    (status),
		.data_out  (data_out)
	);

endmodule

// File: hdl/sbmq_ctrl.sv
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output sbmq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_FIN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign cmd.exec = start && (state_q == S_IDLE);
	assign cmd.fin  = (state_q == S_FIN);

endmodule

// File: hdl/sbmq_dp.sv
module sbmq_dp
	import sbmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbmq_cmd_t            cmd,
	input  logic                 func,
	input  logic [1:0]           queue_num,
	input  logic signed [DW-1:0] data_in,
	output logic                 done,
	output logic [1:0]           status,
	output logic signed [DW-1:0] data_out
);

	logic [PW-1:0]  queue_head_q [QUEUES];
	logic [SIW-1:0] queue_tail_q [QUEUES];
	logic [PW-1:0]  slot_link_q  [SLOTS];
	logic [DW-1:0]  slot_data_q  [SLOTS];
	logic [PW-1:0]  free_head_q;

	logic           enq_s1;
	logic           deq_s1;
	logic [SIW-1:0] slot_s1;
	logic [1:0]     status_s1;
	logic [DW-1:0]  data_rd_s1;

	logic           done_q;
	logic [1:0]     status_q;
	logic [DW-1:0]  data_out_q;

	logic           q_valid;
	logic [QIW-1:0] qidx;
	logic [PW-1:0]  hd;
	logic           hd_valid;
	logic           fh_valid;
	logic [SIW-1:0] fh_idx;
	logic [SIW-1:0] hd_idx;
	logic [SIW-1:0] tail_idx;
	logic           enq_ok;
	logic           deq_ok;
	logic [PW-1:0]  link_rd;

	assign q_valid  = int'(queue_num) < QUEUES;
	assign qidx     = QIW'(queue_num);
	assign hd       = queue_head_q[qidx];
	assign hd_valid = int'(hd) < SLOTS;
	assign fh_valid = int'(free_head_q) < SLOTS;
	assign fh_idx   = free_head_q[SIW-1:0];
	assign hd_idx   = hd[SIW-1:0];
	assign tail_idx = queue_tail_q[qidx];
	assign enq_ok   = cmd.exec && (func == FUNC_ENQ) && q_valid && fh_valid;
	assign deq_ok   = cmd.exec && (func == FUNC_DEQ) && q_valid && hd_valid;
	assign link_rd  = slot_link_q[(func == FUNC_ENQ) ? fh_idx : hd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_link_q[i] <= PW'(i + 1);
			end
		end else if (enq_ok && hd_valid) begin
			slot_link_q[tail_idx] <= free_head_q;
		end else if (deq_ok) begin
			slot_link_q[hd_idx] <= free_head_q;
		end else if (cmd.fin && enq_s1) begin
			slot_link_q[slot_s1] <= NULL_PTR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				queue_head_q[i] <= NULL_PTR;
			end
			free_head_q <= '0;
			enq_s1      <= 1'b0;
			deq_s1      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (enq_ok) begin
				free_head_q <= link_rd;
				if (!hd_valid) queue_head_q[qidx] <= free_head_q;
			end else if (deq_ok) begin
				free_head_q        <= hd;
				queue_head_q[qidx] <= link_rd;
			end
			if (cmd.exec) begin
				enq_s1 <= enq_ok;
				deq_s1 <= deq_ok;
			end
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (enq_ok) begin
			queue_tail_q[qidx]  <= fh_idx;
			slot_data_q[fh_idx] <= data_in;
		end
		if (cmd.exec) begin
			data_rd_s1 <= slot_data_q[hd_idx];
			slot_s1    <= fh_idx;
			if (func == FUNC_ENQ) begin
				status_s1 <= enq_ok ? ST_OK : ST_FULL;
			end else begin
				status_s1 <= deq_ok ? ST_OK : ST_EMPTY;
			end
		end
		if (cmd.fin) begin
			status_q   <= status_s1;
			data_out_q <= deq_s1 ? data_rd_s1 : '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = data_out_q;

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.fin))
		else $error("Result strobe without a finishing cycle.");

	a_enq_moves_free: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> free_head_q != $past(free_head_q))
		else $error("Enqueue left the free-list head in place.");

	a_deq_pushes_free: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |=> free_head_q == $past(hd))
		else $error("Dequeued slot did not become the free-list head.");

endmodule

// File: test/sbmq_checker.sv
`timescale 1ns / 1ps
module sbmq_checker
	import sbmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 func,
	input  logic [1:0]           queue_num,
	input  logic signed [DW-1:0] data_in,
	input  logic                 done,
	input  logic [1:0]           status,
	input  logic signed [DW-1:0] data_out,
	output int                   mismatches,
	output int                   awaiting
);

	typedef logic [PW-1:0] slot_ptr_t;

	typedef struct packed {
		logic [1:0]    st;
		logic [DW-1:0] word;
	} outcome_t;

	slot_ptr_t     head_of [QUEUES];
	slot_ptr_t     tail_of [QUEUES];
	slot_ptr_t     next_of [SLOTS];
	logic [DW-1:0] word_of [SLOTS];
	slot_ptr_t     free_top;
	outcome_t      due_outcomes[$];

	function automatic bit holds_slot(slot_ptr_t p);
		return int'(p) < SLOTS;
	endfunction

	// Applies one command to the shadow queues and returns the outcome it must produce.
	function automatic outcome_t apply_cmd(logic f, logic [1:0] q, logic [DW-1:0] d);
		outcome_t  r;
		slot_ptr_t s;
		r.st   = ST_OK;
		r.word = '0;
		if (f == FUNC_ENQ) begin
			s = free_top;
			if (int'(q) >= QUEUES || !holds_slot(s)) begin
				r.st = ST_FULL;
			end else begin
				free_top = next_of[s];
				if (!holds_slot(head_of[q])) begin
					head_of[q] = s;
				end else if (holds_slot(tail_of[q])) begin
					next_of[tail_of[q]] = s;
				end
				next_of[s] = NULL_PTR;
				tail_of[q] = s;
				word_of[s] = d;
			end
		end else begin
			s = (int'(q) < QUEUES) ? head_of[q] : NULL_PTR;
			if (!holds_slot(s)) begin
				r.st = ST_EMPTY;
			end else begin
				head_of[q] = next_of[s];
				next_of[s] = free_top;
				free_top   = s;
				r.word     = word_of[s];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_of[i] = NULL_PTR;
				tail_of[i] = '0;
			end
			for (int i = 0; i < SLOTS; i++) begin
				next_of[i] = slot_ptr_t'(i + 1);
				word_of[i] = '0;
			end
			free_top = '0;
			due_outcomes.delete();
			mismatches = 0;
			awaiting   = 0;
		end else begin
			if (start && !busy) begin
				due_outcomes.push_back(apply_cmd(func, queue_num, data_in));
			end
			if (done) begin
				if (due_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got status %0d data %h",
						$time, status, data_out);
				end else begin
					want = due_outcomes.pop_front();
					if (status !== want.st) begin
						mismatches++;
						$display("%0t: status expected %0d, actual %0d",
							$time, want.st, status);
					end
					if (data_out !== want.word) begin
						mismatches++;
						$display("%0t: data_out expected %h, actual %h",
							$time, want.word, data_out);
					end
				end
			end
			awaiting = due_outcomes.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top
	import sbmq_pkg::*;
();

	localparam int ITEM_TARGET = 1500;
	localparam int STALL_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 func;
	logic [1:0]           queue_num;
	logic signed [DW-1:0] data_in;
	logic                 done;
	logic [1:0]           status;
	logic signed [DW-1:0] data_out;
	int                   mismatches;
	int                   awaiting;
	int                   issued;
	int                   idle_cycles;

	shared_buffer_multi_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.queue_num (queue_num),
		.data_in   (data_in),
		.done      (done),
		.status    (status),
		.data_out  (data_out)
	);

	sbmq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.queue_num  (queue_num),
		.data_in    (data_in),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Holds one command on the bus until it is accepted; returns at the next falling edge.
	task automatic issue_op(logic f, logic [1:0] q, logic [DW-1:0] d);
		start     <= 1'b1;
		func      <= f;
		queue_num <= q;
		data_in   <= d;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		issued++;
	endtask

	task automatic pause_cmds(int n);
		if (n > 0) begin
			start   <= 1'b0;
			data_in <= $urandom;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int         enq_pct;
		int         focus;
		int         phase_left;
		int         burst;
		bit         gaps_on;
		logic       f;
		logic [1:0] q;
		arst_n    = 1'b0;
		start     = 1'b0;
		func      = FUNC_ENQ;
		queue_num = '0;
		data_in   = '0;
		issued    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every queue starts out empty, then each one is given one of the extreme data words.
		for (int i = 0; i < QUEUES; i++) begin
			issue_op(FUNC_DEQ, 2'(i), $urandom);
		end
		issue_op(FUNC_ENQ, 2'd0, 32'h7fff_ffff);
		issue_op(FUNC_ENQ, 2'd1, 32'h8000_0000);
		pause_cmds(3);
		issue_op(FUNC_ENQ, 2'd2, 32'h0000_0000);
		issue_op(FUNC_ENQ, 2'd3, 32'hffff_ffff);
		issue_op(FUNC_ENQ, 2'd0, 32'haaaa_aaaa);
		issue_op(FUNC_ENQ, 2'd0, 32'h5555_5555);
		repeat (3) issue_op(FUNC_DEQ, 2'd0, $urandom);
		issue_op(FUNC_DEQ, 2'd1, $urandom);
		issue_op(FUNC_DEQ, 2'd2, $urandom);
		issue_op(FUNC_DEQ, 2'd3, $urandom);
		issue_op(FUNC_DEQ, 2'd0, $urandom);

		// Phases lean toward filling, draining or mixing so that the free list runs dry often.
		while (issued < ITEM_TARGET) begin
			case ($urandom_range(0, 2))
				0:       enq_pct = 90;
				1:       enq_pct = 15;
				default: enq_pct = 50;
			endcase
			focus      = $urandom_range(0, QUEUES);
			gaps_on    = ($urandom_range(0, 3) != 0);
			phase_left = $urandom_range(20, 60);
			while (phase_left > 0 && issued < ITEM_TARGET) begin
				burst = $urandom_range(1, 12);
				while (burst > 0 && phase_left > 0) begin
					f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
					if (focus < QUEUES && $urandom_range(0, 4) != 0) begin
						q = 2'(focus);
					end else begin
						q = 2'($urandom_range(0, 3));
					end
					issue_op(f, q, pick_word());
					burst--;
					phase_left--;
				end
				if (gaps_on) begin
					pause_cmds($urandom_range(0, 6));
				end
			end
		end
		start <= 1'b0;

		wait (awaiting == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
